FILE: hdl/smpt_pkg.sv
// Package: shared types, protocol codes and framing tables for the mouse translator.
`timescale 1ns / 1ps

package smpt_pkg;

	typedef enum logic [1:0] {
		MT_SEVEN_BIT = 2'd0,
		MT_FIVE_A    = 2'd1,
		MT_SIGN_MAG  = 2'd2,
		MT_FIVE_B    = 2'd3
	} mtype_t;

	localparam int unsigned PKT_MAX   = 5;
	localparam int unsigned Q_DEPTH   = 2;
	localparam logic [7:0]  SYNC_BYTE = 8'h80;
	localparam logic [7:0]  OUT_HDR   = 8'h40;

	// One translated packet, already in output byte form.
	typedef struct packed {
		logic [7:0] b0;
		logic [5:0] b1;
		logic [5:0] b2;
	} pkt_t;

	// Queue status seen by the front and back ends.
	typedef struct packed {
		logic full;
		logic not_empty;
	} q_stat_t;

	function automatic logic [7:0] hdr_mask(input mtype_t t);
		case (t)
			MT_SEVEN_BIT: hdr_mask = 8'h40;
			MT_SIGN_MAG:  hdr_mask = 8'he0;
			default:      hdr_mask = 8'hf8;
		endcase
	endfunction

	function automatic logic [7:0] hdr_id(input mtype_t t);
		case (t)
			MT_SEVEN_BIT: hdr_id = 8'h40;
			default:      hdr_id = 8'h80;
		endcase
	endfunction

	// Data id is zero for every type; only the mask differs.
	function automatic logic [7:0] dat_mask(input mtype_t t);
		case (t)
			MT_SEVEN_BIT: dat_mask = 8'h40;
			MT_SIGN_MAG:  dat_mask = 8'h80;
			default:      dat_mask = 8'h00;
		endcase
	endfunction

	function automatic logic [2:0] pkt_len(input mtype_t t);
		case (t)
			MT_SEVEN_BIT: pkt_len = 3'd3;
			MT_SIGN_MAG:  pkt_len = 3'd3;
			default:      pkt_len = 3'd5;
		endcase
	endfunction

endpackage

FILE: hdl/smpt_front.sv
// Front end: protocol register, packet framing and decode into a translated packet.
`timescale 1ns / 1ps

module smpt_front import smpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	input  q_stat_t    q_stat,
	output logic       push,
	output pkt_t       push_pkt
);

	mtype_t     type_q;
	logic [2:0] pos_q;
	logic [7:0] bytes_q [PKT_MAX];

	logic       acc;
	logic [2:0] p0;
	logic [2:0] p1;
	logic       bad;
	logic       store;
	logic [2:0] np;
	logic       done;
	logic [7:0] bv [PKT_MAX];
	logic [2:0] buttons;
	logic [7:0] dx;
	logic [7:0] dy;
	logic [7:0] sum;

	assign rx_ready = !q_stat.full;
	assign acc      = rx_valid && rx_ready;

	always_comb begin
		p0    = (pos_q >= pkt_len(type_q)) ? 3'd0 : pos_q;
		bad   = (p0 != 3'd0) &&
		        (((rx_byte & dat_mask(type_q)) != 8'h00) || (rx_byte == SYNC_BYTE));
		p1    = bad ? 3'd0 : p0;
		store = (p1 != 3'd0) || ((rx_byte & hdr_mask(type_q)) == hdr_id(type_q));
		np    = p1 + 3'd1;
		done  = store && (np == pkt_len(type_q));
	end

	// Packet view with the incoming byte in its slot.
	always_comb begin
		for (int i = 0; i < PKT_MAX; i++) begin
			bv[i] = (p1 == 3'(i)) ? rx_byte : bytes_q[i];
		end
	end

	always_comb begin
		sum = 8'h00;
		case (type_q)
			MT_SEVEN_BIT: begin
				buttons = {bv[0][5], 1'b0, bv[0][4]};
				dx      = {bv[0][1:0], bv[1][5:0]};
				dy      = {bv[0][3:2], bv[2][5:0]};
			end
			MT_SIGN_MAG: begin
				buttons = bv[0][2:0];
				dx      = bv[0][4] ? bv[1] : 8'(-bv[1]);
				dy      = bv[0][3] ? 8'(-bv[2]) : bv[2];
			end
			default: begin
				buttons = ~bv[0][2:0];
				dx      = bv[1] + bv[3];
				sum     = bv[2] + bv[4];
				dy      = 8'(-sum);
			end
		endcase
		push_pkt.b0 = OUT_HDR | {2'b00, buttons[2], buttons[0], dy[7:6], dx[7:6]};
		push_pkt.b1 = dx[5:0];
		push_pkt.b2 = dy[5:0];
	end

	assign push = acc && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= MT_SEVEN_BIT;
			pos_q  <= 3'd0;
		end else if (cfg_wr_en) begin
			type_q <= mtype_t'(cfg_wr_data);
			pos_q  <= 3'd0;
		end else if (acc) begin
			if (!store || done) begin
				pos_q <= 3'd0;
			end else begin
				pos_q <= np;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < PKT_MAX; i++) begin
			if (acc && store && (p1 == 3'(i))) begin
				bytes_q[i] <= rx_byte;
			end
		end
	end

endmodule

FILE: hdl/smpt_queue.sv
// Two-entry packet queue between front and back ends.
`timescale 1ns / 1ps

module smpt_queue import smpt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  pkt_t    push_pkt,
	input  logic    pop,
	output pkt_t    head,
	output q_stat_t q_stat
);

	localparam int unsigned PW = $clog2(Q_DEPTH);
	localparam int unsigned CW = $clog2(Q_DEPTH + 1);

	pkt_t          mem_q [Q_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign head             = mem_q[rd_q];
	assign q_stat.full      = (cnt_q == CW'(Q_DEPTH));
	assign q_stat.not_empty = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(Q_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_pkt;
		end
	end

endmodule

FILE: hdl/smpt_back.sv
// Back end: serializes each queued packet into three output bytes.
`timescale 1ns / 1ps

module smpt_back import smpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_stat_t    q_stat,
	input  pkt_t       head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] byte_number,
	output logic       last_byte
);

	pkt_t       pkt_q;
	logic       have_q;
	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic [1:0] num_q;
	logic       last_q;

	logic       adv;
	logic       src_ok;
	pkt_t       src;
	logic [1:0] idx;
	logic [7:0] sel;

	assign adv    = !valid_q || out_ready;
	assign src_ok = have_q || q_stat.not_empty;
	assign src    = have_q ? pkt_q : head;
	assign idx    = have_q ? idx_q : 2'd0;
	assign pop    = adv && !have_q && q_stat.not_empty;

	always_comb begin
		case (idx)
			2'd0:    sel = src.b0;
			2'd1:    sel = {2'b00, src.b1};
			default: sel = {2'b00, src.b2};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= src_ok;
			if (pop) begin
				have_q <= 1'b1;
				idx_q  <= 2'd1;
			end else if (have_q) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd2) begin
					have_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pkt_q <= head;
		end
		if (adv && src_ok) begin
			byte_q <= sel;
			num_q  <= idx;
			last_q <= (idx == 2'd2);
		end
	end

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign byte_number = num_q;
	assign last_byte   = last_q;

endmodule

FILE: hdl/serial_mouse_packet_translator_unit.sv
// Byte 0 of a packet passes the queue entry, then the registered output stage.
// Bytes 1 and 2 follow in order, each held while out_ready is low.
// Input: one item per cycle while the two-packet queue has room (rx_ready = not full).
// Sustained rate is set by the back-end serializer: three output bytes per packet.
// Reset (arst_n low, async): protocol type 0, framing position 0, queue and output empty.
`timescale 1ns / 1ps

module serial_mouse_packet_translator_unit import smpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// protocol register write (mouse_type); restarts framing
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	// received mouse bytes
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	// translated three-byte packets
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] byte_number,
	output logic       last_byte
);

	// Front end frames bytes and decodes a full packet in the cycle its last
	// byte arrives; the result goes straight into the queue.
	q_stat_t q_stat;
	logic    push;
	pkt_t    push_pkt;
	logic    pop;
	pkt_t    head;

	smpt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rx_valid    (rx_valid),
		.rx_ready    (rx_ready),
		.rx_byte     (rx_byte),
		.q_stat      (q_stat),
		.push        (push),
		.push_pkt    (push_pkt)
	);

	// Queue decouples framing from output stalls.
	smpt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_pkt (push_pkt),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// Back end sends byte 0 straight from the queue head, then bytes 1, 2
	// from its held copy, through a registered output stage.
	smpt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_number (byte_number),
		.last_byte   (last_byte)
	);

endmodule

FILE: hdl/smpt_checker.sv
// Port-level checker for the mouse translator, bound to the top level.
`timescale 1ns / 1ps

module smpt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [1:0] byte_number,
	input logic       last_byte
);

	// last marks byte 2 only, and no position beyond 2
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_byte == (byte_number == 2'd2)) && (byte_number != 2'd3))
		else $error("last_byte / byte_number mismatch");

	// byte 0 carries the sync bit, data bytes carry only six bits
	a_byte_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((byte_number == 2'd0) ? (out_byte[7:6] == 2'b01)
		                                      : (out_byte[7:6] == 2'b00)))
		else $error("output byte format wrong");

	// within a packet the next byte follows in the next cycle
	a_packet_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (byte_number != 2'd2) |=>
		out_valid && (byte_number == $past(byte_number) + 2'd1))
		else $error("packet bytes not contiguous");

	// a stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		out_valid && $stable(out_byte) && $stable(byte_number))
		else $error("stalled output item changed");

endmodule

bind serial_mouse_packet_translator_unit smpt_checker u_smpt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_byte    (out_byte),
	.byte_number (byte_number),
	.last_byte   (last_byte)
);
